[design/crdep_pkg.sv]
// ----------------------------------------------------------------------------
// crdep_pkg: shared definitions for the config ROM directory entry parser
// Holds the key type codes, recognized key ids, the result kind encoding and
// the field widths that the parser and its checker use.
// ----------------------------------------------------------------------------
package crdep_pkg;

  localparam int unsigned QuadletW = 32;
  localparam int unsigned ValueW   = 24;
  localparam int unsigned AvailW   = 9;
  localparam int unsigned LimitW   = 8;
  localparam int unsigned IndexW   = 9;

  localparam logic [AvailW-1:0] AvailSat = 9'd256;
  localparam logic [IndexW-1:0] IndexMax = 9'd511;

  // Key type codes (upper two bits of an entry quadlet).
  localparam logic [1:0] KT_IMMEDIATE = 2'd0;
  localparam logic [1:0] KT_CSR_OFF   = 2'd1;
  localparam logic [1:0] KT_LEAF      = 2'd2;
  localparam logic [1:0] KT_DIRECTORY = 2'd3;

  // Recognized key ids.
  localparam logic [5:0] KID_TEXT_DESC = 6'h01;
  localparam logic [5:0] KID_VENDOR    = 6'h03;
  localparam logic [5:0] KID_MODEL     = 6'h17;
  localparam logic [5:0] KID_UNIT_SPEC = 6'h12;
  localparam logic [5:0] KID_UNIT_SW   = 6'h13;
  localparam logic [5:0] KID_LUN       = 6'h14;
  localparam logic [5:0] KID_NODE_CAPS = 6'h0C;
  localparam logic [5:0] KID_UNIT_DIR  = 6'h11;

  typedef enum logic [2:0] {
    KIND_TEXT_DESC = 3'd0,
    KIND_VENDOR    = 3'd1,
    KIND_MODEL     = 3'd2,
    KIND_UNIT_SPEC = 3'd3,
    KIND_UNIT_SW   = 3'd4,
    KIND_LUN       = 3'd5,
    KIND_NODE_CAPS = 3'd6,
    KIND_UNIT_DIR  = 3'd7
  } entry_kind_e;

endpackage

[design/config_rom_directory_entry_parser_unit.sv]
// ----------------------------------------------------------------------------
// config_rom_directory_entry_parser_unit: directory entry parser
// Walks the quadlets of a configuration ROM directory, bounds the scan by the
// header length, the available quadlets and a programmable cap, and reports
// the recognized entries with their directory-relative target offsets.
// ----------------------------------------------------------------------------
//
//  Channel | Signals                                   | Direction
//  --------+-------------------------------------------+-------------------
//  cfg     | cfg_valid_i, cfg_ready_o, cfg_data_i      | register write in
//  in      | in_valid_i, in_stall_o, is_header_i,      | quadlet word in
//          | quadlet_i, available_quadlets_i           |
//  out     | out_valid_o, out_stall_i, entry_kind_o,   | entry word out
//          | key_type_o, entry_value_o, target_offset_o|
//
// One word is accepted per cycle when nothing stalls. A recognized entry
// passes through the entry register and then the result register, which
// drives the output until the word is taken. Headers and entries that are
// outside the scan window or not recognized leave the pipe without a result.
// Reset clears the scan window, the entry counter and all valid flags and
// sets the scan cap to 255. A stalled output holds its word; the entry
// register keeps draining into an empty result register, so the input stalls
// only when both registers are full and the output is stalled.
module config_rom_directory_entry_parser_unit
  import crdep_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,

  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [LimitW-1:0]   cfg_data_i,

  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                is_header_i,
  input  logic [QuadletW-1:0] quadlet_i,
  input  logic [AvailW-1:0]   available_quadlets_i,

  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [2:0]          entry_kind_o,
  output logic [1:0]          key_type_o,
  output logic [ValueW-1:0]   entry_value_o,
  output logic [ValueW-1:0]   target_offset_o
);

  // --------------------------------------------------------------------------
  // Directory state and the scan cap register.
  // --------------------------------------------------------------------------
  logic [LimitW-1:0] max_scan_q;
  logic [LimitW-1:0] scan_limit_q, scan_limit_d;
  logic [AvailW-1:0] avail_q, avail_d;
  logic [IndexW-1:0] index_q, index_d;

  // Entry register (first stage) and result register (second stage).
  logic                s1_valid_q, s1_valid_d;
  logic [QuadletW-1:0] s1_quadlet_q;
  logic [IndexW-1:0]   s1_index_q;

  logic                out_valid_q, out_valid_d;
  entry_kind_e         kind_q, kind_d;
  logic [1:0]          kt_q;
  logic [ValueW-1:0]   value_q;
  logic [ValueW-1:0]   target_q, target_d;

  logic in_accept;
  logic s2_load;
  logic s1_free;

  // The result register takes a new word when it is empty or being drained.
  assign s2_load   = !out_valid_q || !out_stall_i;
  assign s1_free   = !s1_valid_q || s2_load;
  assign in_stall_o = !s1_free;
  assign in_accept = in_valid_i && s1_free;
  assign cfg_ready_o = 1'b1;

  // --------------------------------------------------------------------------
  // Header handling and entry counting, done as each word is accepted.
  // --------------------------------------------------------------------------
  logic [AvailW-1:0] avail_sat;
  logic [AvailW-1:0] avail_m1;
  logic [15:0]       hdr_len;
  logic [15:0]       lim_a;
  logic [15:0]       lim_b;
  logic [IndexW-1:0] index_inc;
  logic              in_window;

  always_comb begin
    avail_sat = (available_quadlets_i > AvailSat) ? AvailSat : available_quadlets_i;
    avail_m1  = avail_sat - AvailW'(1);
    hdr_len   = quadlet_i[31:16];
    // The available count only lowers the limit when it leaves room for entries.
    if ((avail_sat > AvailW'(1)) && ({7'd0, avail_m1} < hdr_len)) begin
      lim_a = {7'd0, avail_m1};
    end else begin
      lim_a = hdr_len;
    end
    lim_b = (lim_a > {8'd0, max_scan_q}) ? {8'd0, max_scan_q} : lim_a;

    index_inc = (index_q < IndexMax) ? (index_q + IndexW'(1)) : index_q;
    in_window = (index_inc <= {1'b0, scan_limit_q}) && (index_inc < avail_q);

    scan_limit_d = scan_limit_q;
    avail_d      = avail_q;
    index_d      = index_q;
    s1_valid_d   = s1_valid_q && !s2_load;
    if (in_accept) begin
      if (is_header_i) begin
        scan_limit_d = lim_b[LimitW-1:0];
        avail_d      = avail_sat;
        index_d      = '0;
        s1_valid_d   = 1'b0;
      end else begin
        index_d    = index_inc;
        s1_valid_d = in_window;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Entry decode: key type, key id and the signed target offset.
  // --------------------------------------------------------------------------
  logic [1:0]        kt;
  logic [5:0]        kid;
  logic [ValueW-1:0] value;
  logic signed [ValueW:0] rel;
  logic              leaf_or_dir;
  logic              hit;

  always_comb begin
    kt          = s1_quadlet_q[31:30];
    kid         = s1_quadlet_q[29:24];
    value       = s1_quadlet_q[ValueW-1:0];
    leaf_or_dir = (kt == KT_LEAF) || (kt == KT_DIRECTORY);
    // Entry index plus the sign-extended 24-bit value; a negative sum is 0.
    rel = $signed({16'd0, s1_index_q}) + $signed({value[ValueW-1], value});
    if (!leaf_or_dir || rel[ValueW]) begin
      target_d = '0;
    end else begin
      target_d = rel[ValueW-1:0];
    end

    hit    = 1'b0;
    kind_d = KIND_TEXT_DESC;
    case (kid)
      KID_TEXT_DESC: begin
        hit    = leaf_or_dir && (target_d != '0);
        kind_d = KIND_TEXT_DESC;
      end
      KID_VENDOR: begin
        hit    = (kt == KT_IMMEDIATE);
        kind_d = KIND_VENDOR;
      end
      KID_MODEL: begin
        hit    = (kt == KT_IMMEDIATE);
        kind_d = KIND_MODEL;
      end
      KID_UNIT_SPEC: begin
        hit    = (kt == KT_IMMEDIATE);
        kind_d = KIND_UNIT_SPEC;
      end
      KID_UNIT_SW: begin
        hit    = (kt == KT_IMMEDIATE);
        kind_d = KIND_UNIT_SW;
      end
      KID_LUN: begin
        hit    = (kt == KT_IMMEDIATE);
        kind_d = KIND_LUN;
      end
      KID_NODE_CAPS: begin
        hit    = (kt == KT_IMMEDIATE);
        kind_d = KIND_NODE_CAPS;
      end
      KID_UNIT_DIR: begin
        hit    = (kt == KT_DIRECTORY);
        kind_d = KIND_UNIT_DIR;
      end
      default: begin
        hit    = 1'b0;
        kind_d = KIND_TEXT_DESC;
      end
    endcase

    out_valid_d = s2_load ? (s1_valid_q && hit) : out_valid_q;
  end

  // --------------------------------------------------------------------------
  // Registers.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_scan_q   <= 8'd255;
      scan_limit_q <= '0;
      avail_q      <= '0;
      index_q      <= '0;
      s1_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        max_scan_q <= cfg_data_i;
      end
      scan_limit_q <= scan_limit_d;
      avail_q      <= avail_d;
      index_q      <= index_d;
      s1_valid_q   <= s1_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept && !is_header_i) begin
      s1_quadlet_q <= quadlet_i;
      s1_index_q   <= index_inc;
    end
    if (s2_load && s1_valid_q && hit) begin
      kind_q   <= kind_d;
      kt_q     <= kt;
      value_q  <= value;
      target_q <= target_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign entry_kind_o    = kind_q;
  assign key_type_o      = kt_q;
  assign entry_value_o   = value_q;
  assign target_offset_o = target_q;

endmodule

[design/crdep_checker.sv]
// ----------------------------------------------------------------------------
// crdep_checker: port-level checks for the directory entry parser
// Watches the output channel and checks the handshake and the consistency
// of the reported kind, key type and target offset.
// ----------------------------------------------------------------------------
module crdep_checker
  import crdep_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic [2:0]        entry_kind_o,
  input logic [1:0]        key_type_o,
  input logic [ValueW-1:0] entry_value_o,
  input logic [ValueW-1:0] target_offset_o
);

  // A stalled result stays valid.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // A stalled result keeps its fields.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(entry_kind_o) && $stable(key_type_o)
      && $stable(entry_value_o) && $stable(target_offset_o))
    else $error("stalled result changed");

  // Immediate kinds carry an immediate key type and no target.
  a_imm_kinds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (entry_kind_o == KIND_VENDOR || entry_kind_o == KIND_MODEL ||
      entry_kind_o == KIND_UNIT_SPEC || entry_kind_o == KIND_UNIT_SW ||
      entry_kind_o == KIND_LUN || entry_kind_o == KIND_NODE_CAPS)
    |-> key_type_o == KT_IMMEDIATE && target_offset_o == '0)
    else $error("immediate entry with bad key type or target");

  // A unit directory is always a directory entry.
  a_unit_dir: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && entry_kind_o == KIND_UNIT_DIR |-> key_type_o == KT_DIRECTORY)
    else $error("unit directory with wrong key type");

  // A text descriptor points somewhere through a leaf or directory.
  a_text_desc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && entry_kind_o == KIND_TEXT_DESC
    |-> target_offset_o != '0 && (key_type_o == KT_LEAF || key_type_o == KT_DIRECTORY))
    else $error("text descriptor without a target");

endmodule

bind config_rom_directory_entry_parser_unit crdep_checker u_crdep_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .entry_kind_o    (entry_kind_o),
  .key_type_o      (key_type_o),
  .entry_value_o   (entry_value_o),
  .target_offset_o (target_offset_o)
);

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: self-checking bench for config_rom_directory_entry_parser_unit
// Feeds directory headers and entry words to the parser while both sides
// idle at random, predicts the recognized entries in parallel, and checks
// every result word field by field, in order, against those predictions.
// ----------------------------------------------------------------------------
module testbench;
  import crdep_pkg::*;

  localparam int unsigned ClkHalf     = 5;
  localparam int unsigned ResetCycles = 7;
  // Two pipeline registers sit between input and output; the extra drain wait
  // makes sure nothing is still in flight before a cap write or the end.
  localparam int unsigned DrainCycles = 4;
  localparam int unsigned RandomWords = 170;
  localparam int unsigned QuietWords  = 60;
  localparam int unsigned HoldCycles  = 80;
  localparam int unsigned CycleLimit  = 500000;
  localparam int unsigned MaxReports  = 10;

  // One predicted result word, laid out like the output ports.
  typedef struct packed {
    entry_kind_e         kind;
    logic [1:0]          ktype;
    logic [ValueW-1:0]   value;
    logic [ValueW-1:0]   target;
  } dir_entry_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [LimitW-1:0]   cfg_data_i;
  logic                in_valid_i;
  logic                in_stall_o;
  logic                is_header_i;
  logic [QuadletW-1:0] quadlet_i;
  logic [AvailW-1:0]   available_quadlets_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [2:0]          entry_kind_o;
  logic [1:0]          key_type_o;
  logic [ValueW-1:0]   entry_value_o;
  logic [ValueW-1:0]   target_offset_o;

  // Predictor state: a private copy of the scan window and entry counter,
  // plus the cap register as last written. Values match the reset state.
  logic [LimitW-1:0]   cap_reg      = 8'd255;
  logic [LimitW-1:0]   window_limit = '0;
  logic [AvailW-1:0]   avail_seen   = '0;
  logic [IndexW-1:0]   entries_seen = '0;

  dir_entry_t          pending_entries[$];
  int unsigned         mismatch_count = 0;
  int unsigned         cycle_count    = 0;

  // Idling controls shared by the tests and the two driver processes.
  bit                  tx_idle_on  = 1'b1;
  bit                  rx_idle_on  = 1'b1;
  int unsigned         rx_hold_len = 0;

  config_rom_directory_entry_parser_unit uut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_valid_i          (cfg_valid_i),
    .cfg_ready_o          (cfg_ready_o),
    .cfg_data_i           (cfg_data_i),
    .in_valid_i           (in_valid_i),
    .in_stall_o           (in_stall_o),
    .is_header_i          (is_header_i),
    .quadlet_i            (quadlet_i),
    .available_quadlets_i (available_quadlets_i),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .entry_kind_o         (entry_kind_o),
    .key_type_o           (key_type_o),
    .entry_value_o        (entry_value_o),
    .target_offset_o      (target_offset_o)
  );

  always #(ClkHalf) clk_i = ~clk_i;

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("config_rom_directory_entry_parser_unit verification failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // Updates the predicted state for one accepted word and queues the result
  // word it should produce, if any. A header only reshapes the scan window.
  function automatic void predict_word(input bit hdr, input logic [QuadletW-1:0] q,
                                       input logic [AvailW-1:0] avail);
    int unsigned lim;
    int unsigned avl;
    int          rel;
    logic [1:0]        kt;
    logic [5:0]        kid;
    logic [ValueW-1:0] val;
    logic [ValueW-1:0] tgt;
    bit          hit;
    dir_entry_t  e;
    if (hdr) begin
      // The window is the directory length, trimmed to the quadlets that
      // follow the header (when more than one is available) and to the cap.
      lim = {16'd0, q[31:16]};
      avl = {23'd0, ((avail > AvailSat) ? AvailSat : avail)};
      avail_seen = avl[AvailW-1:0];
      if (avl > 1 && avl - 1 < lim) lim = avl - 1;
      if (lim > {24'd0, cap_reg}) lim = {24'd0, cap_reg};
      window_limit = lim[LimitW-1:0];
      entries_seen = '0;
      return;
    end
    if (entries_seen < IndexMax) entries_seen++;
    if (entries_seen > window_limit || entries_seen >= avail_seen) return;

    kt  = q[31:30];
    kid = q[29:24];
    val = q[ValueW-1:0];
    // Leaf and directory values are signed offsets from the entry itself;
    // anything landing before the directory start clamps to zero.
    tgt = '0;
    if (kt == KT_LEAF || kt == KT_DIRECTORY) begin
      rel = int'(entries_seen) + int'($signed(val));
      if (rel > 0) tgt = rel[ValueW-1:0];
    end

    e.ktype  = kt;
    e.value  = val;
    e.target = '0;
    e.kind   = KIND_TEXT_DESC;
    hit = (kt == KT_IMMEDIATE);
    case (kid)
      KID_VENDOR:    e.kind = KIND_VENDOR;
      KID_MODEL:     e.kind = KIND_MODEL;
      KID_UNIT_SPEC: e.kind = KIND_UNIT_SPEC;
      KID_UNIT_SW:   e.kind = KIND_UNIT_SW;
      KID_LUN:       e.kind = KIND_LUN;
      KID_NODE_CAPS: e.kind = KIND_NODE_CAPS;
      KID_TEXT_DESC: begin
        // A descriptor that points at the directory start is dropped.
        e.kind   = KIND_TEXT_DESC;
        e.target = tgt;
        hit      = (kt == KT_LEAF || kt == KT_DIRECTORY) && tgt != '0;
      end
      KID_UNIT_DIR: begin
        // A unit directory is reported even when its offset clamps to zero.
        e.kind   = KIND_UNIT_DIR;
        e.target = tgt;
        hit      = (kt == KT_DIRECTORY);
      end
      default: hit = 1'b0;
    endcase
    if (hit) pending_entries = {pending_entries, e};
  endfunction

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------

  function automatic void report_mismatch(input string what, input logic [ValueW-1:0] want,
                                          input logic [ValueW-1:0] got);
    mismatch_count++;
    if (mismatch_count <= MaxReports)
      $display("%0t: mismatch on %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
  endfunction

  function automatic void check_field(input string what, input logic [ValueW-1:0] want,
                                      input logic [ValueW-1:0] got);
    if (got !== want) report_mismatch(what, want, got);
  endfunction

  // Every result word taken at an edge is matched against the oldest
  // prediction. Sampling happens before this edge's updates take effect.
  always @(posedge clk_i) begin
    dir_entry_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_entries.size() == 0) begin
        report_mismatch("unexpected result word (value)", '0, entry_value_o);
      end else begin
        want = pending_entries.pop_front();
        check_field("entry kind", ValueW'(want.kind), ValueW'(entry_kind_o));
        check_field("key type", ValueW'(want.ktype), ValueW'(key_type_o));
        check_field("entry value", want.value, entry_value_o);
        check_field("target offset", want.target, target_offset_o);
      end
    end
  end

  // Output side: random stall bursts, and on request one long hold so that
  // both pipeline registers fill and the parser stalls its input.
  initial begin
    int unsigned burst;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rx_hold_len != 0) begin
        out_stall_i <= 1'b1;
        repeat (rx_hold_len) @(posedge clk_i);
        rx_hold_len = 0;
        out_stall_i <= 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 17);
        out_stall_i <= 1'b1;
        repeat (burst) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  function automatic logic [QuadletW-1:0] make_entry(input logic [1:0] kt,
                                                     input logic [5:0] kid,
                                                     input logic [ValueW-1:0] val);
    return {kt, kid, val};
  endfunction

  // Offers one word, optionally after a random gap, holds it steady until
  // the parser takes it, then feeds it to the predictor.
  task automatic send_word(input bit hdr, input logic [QuadletW-1:0] q,
                           input logic [AvailW-1:0] avail);
    int unsigned gap;
    gap = 0;
    if (tx_idle_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 17);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i           <= 1'b1;
    is_header_i          <= hdr;
    quadlet_i            <= q;
    available_quadlets_i <= avail;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_word(hdr, q, avail);
  endtask

  task automatic send_header(input logic [15:0] len, input logic [AvailW-1:0] avail);
    send_word(1'b1, {len, 16'($urandom())}, avail);
  endtask

  // The available count is ignored on entries, so it carries random bits.
  task automatic send_entry(input logic [QuadletW-1:0] q);
    send_word(1'b0, q, AvailW'($urandom()));
  endtask

  // Lets every predicted word come out and the pipe go quiet.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_entries.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // The cap is only rewritten while the parser holds no work.
  task automatic write_cap(input logic [LimitW-1:0] cap);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= cap;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    cap_reg = cap;
  endtask

  // Mostly recognized id/type pairs, some with a wrong type, some noise.
  // Values are often small signed offsets so targets straddle zero.
  function automatic logic [QuadletW-1:0] random_entry();
    logic [ValueW-1:0] val;
    val = $urandom_range(0, 1) ? ValueW'($urandom())
                               : ValueW'($urandom_range(0, 48)) - 24'd24;
    case ($urandom_range(0, 11))
      0:  return make_entry($urandom_range(0, 1) ? KT_LEAF : KT_DIRECTORY,
                            KID_TEXT_DESC, val);
      1:  return make_entry(KT_IMMEDIATE, KID_VENDOR, val);
      2:  return make_entry(KT_IMMEDIATE, KID_MODEL, val);
      3:  return make_entry(KT_IMMEDIATE, KID_UNIT_SPEC, val);
      4:  return make_entry(KT_IMMEDIATE, KID_UNIT_SW, val);
      5:  return make_entry(KT_IMMEDIATE, KID_LUN, val);
      6:  return make_entry(KT_IMMEDIATE, KID_NODE_CAPS, val);
      7:  return make_entry(KT_DIRECTORY, KID_UNIT_DIR, val);
      8:  return make_entry(2'($urandom()), KID_TEXT_DESC, val);
      9:  return make_entry(2'($urandom()), KID_UNIT_DIR, val);
      10: return make_entry(2'($urandom()), KID_VENDOR, val);
      default: return $urandom();
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Right after reset the window is empty, so stray entries are dropped.
  task automatic test_orphan_entries();
    send_entry(make_entry(KT_IMMEDIATE, KID_VENDOR, 24'h00_0001));
    send_entry(make_entry(KT_DIRECTORY, KID_UNIT_DIR, 24'h00_0004));
    send_entry(make_entry(KT_LEAF, KID_TEXT_DESC, 24'h00_0002));
  endtask

  // One directory that visits every kind, the offset corner cases, wrong
  // types, unknown ids and an entry just past the directory length.
  task automatic test_directed_entries();
    send_header(16'd16, 9'd20);
    send_entry(make_entry(KT_IMMEDIATE, KID_VENDOR, 24'hFF_FFFF));
    send_entry(make_entry(KT_IMMEDIATE, KID_MODEL, 24'h00_0000));
    send_entry(make_entry(KT_IMMEDIATE, KID_UNIT_SPEC, 24'h00_A02D));
    send_entry(make_entry(KT_IMMEDIATE, KID_UNIT_SW, 24'h01_0001));
    send_entry(make_entry(KT_IMMEDIATE, KID_LUN, 24'h12_3456));
    send_entry(make_entry(KT_IMMEDIATE, KID_NODE_CAPS, 24'h00_83C0));
    send_entry(make_entry(KT_DIRECTORY, KID_UNIT_DIR, 24'h00_0005));
    // Entry 8 points exactly at the directory start; entry 9 before it.
    send_entry(make_entry(KT_LEAF, KID_TEXT_DESC, 24'hFF_FFF8));
    send_entry(make_entry(KT_DIRECTORY, KID_TEXT_DESC, 24'hFF_FFF0));
    // Most negative offset: clamps to zero but is still reported.
    send_entry(make_entry(KT_DIRECTORY, KID_UNIT_DIR, 24'h80_0000));
    send_entry(make_entry(KT_LEAF, KID_TEXT_DESC, 24'h7F_FFFF));
    send_entry(make_entry(KT_LEAF, KID_VENDOR, 24'h00_0001));
    send_entry(make_entry(KT_IMMEDIATE, KID_UNIT_DIR, 24'h00_0001));
    send_entry(make_entry(KT_CSR_OFF, KID_MODEL, 24'h00_0001));
    send_entry(32'hFFFF_FFFF);
    send_entry(32'h0000_0000);
    send_entry(make_entry(KT_IMMEDIATE, KID_VENDOR, 24'h00_0001));
  endtask

  // Window shaping by the available count: saturation, the zero and one
  // cases, trimming below the length, and an empty directory.
  task automatic test_window_limits();
    send_header(16'hFFFF, 9'h1FF);
    repeat (2) send_entry(make_entry(KT_IMMEDIATE, KID_LUN, 24'h00_0007));
    send_header(16'd5, 9'd0);
    repeat (2) send_entry(make_entry(KT_IMMEDIATE, KID_LUN, 24'h00_0008));
    send_header(16'd5, 9'd1);
    send_entry(make_entry(KT_IMMEDIATE, KID_LUN, 24'h00_0009));
    send_header(16'd10, 9'd3);
    repeat (3) send_entry(make_entry(KT_IMMEDIATE, KID_MODEL, 24'h00_000A));
    send_header(16'd0, 9'd100);
    send_entry(make_entry(KT_IMMEDIATE, KID_MODEL, 24'h00_000B));
  endtask

  // The cap at zero shuts the window, at one allows a single entry, and is
  // left at its full value for the tests that follow.
  task automatic test_scan_cap();
    write_cap(8'd0);
    send_header(16'd10, 9'd20);
    repeat (2) send_entry(make_entry(KT_IMMEDIATE, KID_VENDOR, 24'h00_0010));
    write_cap(8'd1);
    send_header(16'd10, 9'd20);
    repeat (3) send_entry(make_entry(KT_IMMEDIATE, KID_VENDOR, 24'h00_0011));
    write_cap(8'd255);
  endtask

  // A directory longer than the entry counter can count: the widest window
  // is used in full and the counter then saturates quietly.
  task automatic test_counter_saturation();
    send_header(16'hFFFF, 9'h1FF);
    repeat (520) send_entry(random_entry());
  endtask

  // The receiver holds off for a long stretch while words keep coming, so
  // the pipe fills and the parser has to stall its input.
  task automatic test_output_backpressure();
    tx_idle_on  = 1'b0;
    rx_hold_len = HoldCycles;
    send_header(16'd255, 9'd256);
    repeat (24) send_entry(make_entry(KT_IMMEDIATE, KID_NODE_CAPS, 24'($urandom())));
    wait_drained();
    tx_idle_on = 1'b1;
  endtask

  // Random well-formed directories with random content and an occasional
  // cap change; the final stretch runs with no idling at all.
  task automatic test_random_directories();
    int unsigned sent;
    int unsigned len;
    int unsigned avail;
    int unsigned count;
    sent = 0;
    while (sent < RandomWords) begin
      if (sent > RandomWords - QuietWords) begin
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
      end
      if ($urandom_range(0, 5) == 0) begin
        case ($urandom_range(0, 5))
          0:       write_cap(8'd0);
          1:       write_cap(8'd255);
          2:       write_cap(8'd1);
          default: write_cap(8'($urandom_range(2, 254)));
        endcase
      end
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5, 6: len = $urandom_range(0, 24);
        7, 8:                len = $urandom_range(0, 300);
        default:             len = $urandom_range(0, 65535);
      endcase
      if ($urandom_range(0, 4) < 3) avail = len + 1 + $urandom_range(0, 4);
      else avail = $urandom_range(0, 511);
      if (avail > 511) avail = 511;
      send_header(16'(len), 9'(avail));
      count = $urandom_range(0, (len > 40 ? 40 : len) + 3);
      repeat (count) send_entry(random_entry());
      sent += count + 1;
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------

  initial begin
    rst_ni               <= 1'b0;
    cfg_valid_i          <= 1'b0;
    cfg_data_i           <= '0;
    in_valid_i           <= 1'b0;
    is_header_i          <= 1'b0;
    quadlet_i            <= '0;
    available_quadlets_i <= '0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_orphan_entries();
    test_directed_entries();
    test_window_limits();
    test_scan_cap();
    test_output_backpressure();
    test_counter_saturation();
    test_random_directories();
    wait_drained();

    if (mismatch_count == 0) begin
      $display("config_rom_directory_entry_parser_unit verification clean");
    end else begin
      $display("config_rom_directory_entry_parser_unit verification failed");
    end
    $finish;
  end

endmodule

[files.f]
design/crdep_pkg.sv
design/config_rom_directory_entry_parser_unit.sv
design/crdep_checker.sv
tb/testbench.sv
